/* rtl/rsi_pkg.sv */
`timescale 1ns / 1ps

package rsi_pkg;

  // Default formats: signed Q16.16 coordinates
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Load enables for the two register ranks of a squaring unit
  typedef struct packed {
    logic mul;   // partial products rank
    logic sum;   // combined square rank
  } rsi_sq_en_t;

endpackage

/* rtl/ray_sphere_intersect_core.sv */
`timescale 1ns / 1ps

// Ray-sphere intersection, geometric method, fully pipelined. One ray/sphere
// pair is taken per cycle while s_tready is high, and each pair gives one
// result, in order, on m_tdata and m_tuser. The depth is set by
// the square root of the discriminant, which resolves one result bit per
// stage over COORD_BITS + 4 stages; ahead of it sit seven stages for the
// difference vector, the dot products, the squares and the discriminant,
// and one output register follows it. Every stage carries its own valid bit
// and loads whenever it is empty or the stage after it moves, so bubbles
// close up under back-pressure and s_tready stays high while any stage is
// free. The distance is the nearest non-negative root in Q.FRAC_BITS,
// saturated to the positive coordinate range; a miss reports zero.
module ray_sphere_intersect_core #(
  parameter int COORD_BITS = rsi_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // origin_x/y/z, dir_x/y/z, center_x/y/z, sphere_radius (low bits first)
  input  logic [((7*COORD_BITS+3*FRAC_BITS+5+7)/8)*8-1:0] s_tdata,
  input  logic                                            s_tvalid,
  output logic                                            s_tready,
  // hit_distance
  output logic [((COORD_BITS+7)/8)*8-1:0]                 m_tdata,
  // hit
  output logic                                            m_tuser,
  output logic                                            m_tvalid,
  input  logic                                            m_tready
);

  import rsi_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int D    = F + 2;          // direction width
  localparam int RB   = C - 1;          // radius width
  localparam int LW   = C + 1;          // L = center - origin
  localparam int PW   = LW + D;         // L * dir
  localparam int DOTW = C + F + 4;      // L . dir
  localparam int TW   = C + 4;          // tca, signed
  localparam int TMW  = C + 3;          // |tca|
  localparam int LLW  = 2 * C + 2;      // L . L
  localparam int XW   = 2 * C + 8;      // d2 and discriminant, signed
  localparam int SW   = XW;             // radicand width (even)
  localparam int N    = SW / 2;         // root bits
  localparam int RW   = N + 2;          // root remainder
  localparam int OW   = C + 6;          // roots before saturation
  localparam int OUT_W = ((C + 7) / 8) * 8;

  // stage numbering
  localparam int ST_L    = 0;
  localparam int ST_MUL  = 1;
  localparam int ST_TCA  = 2;
  localparam int ST_LL   = 3;
  localparam int ST_TT   = 4;
  localparam int ST_D2   = 5;
  localparam int ST_DISC = 6;
  localparam int ST_SQ   = 7;
  localparam int ST_OUT  = ST_SQ + N;
  localparam int NS      = ST_OUT + 1;

  // ---------------------------------------------------------------------
  // Stage valids and load enables
  // ---------------------------------------------------------------------
  logic [NS-1:0] v;
  logic [NS-1:0] en;
  logic [NS-1:0] v_in;

  // a stage loads when it, or any stage after it, is empty, or the sink takes
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = m_tready || !(&v[NS-1:k]);
  end

  assign v_in     = {v[NS-2:0], s_tvalid};
  assign s_tready = en[ST_L];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v_in[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input unpacking
  // ---------------------------------------------------------------------
  logic signed [C-1:0]  org   [3];
  logic signed [C-1:0]  ctr   [3];
  logic signed [D-1:0]  dir_i [3];
  logic        [RB-1:0] rad_i;
  logic signed [LW-1:0] ldiff [3];
  logic signed [LW-1:0] lrev  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      org[i]   = s_tdata[i*C +: C];
      dir_i[i] = s_tdata[3*C + i*D +: D];
      ctr[i]   = s_tdata[3*C + 3*D + i*C +: C];
      ldiff[i] = LW'(ctr[i]) - LW'(org[i]);
      lrev[i]  = LW'(org[i]) - LW'(ctr[i]);
    end
    rad_i = s_tdata[6*C + 3*D +: RB];
  end

  // ---------------------------------------------------------------------
  // Stage L: difference vector and its magnitude
  // ---------------------------------------------------------------------
  logic signed [LW-1:0] l_s1    [3];
  logic        [LW-1:0] lmag_s1 [3];
  logic signed [D-1:0]  dir_s1  [3];
  logic        [RB-1:0] rad_s1;

  always_ff @(posedge clk) begin
    if (en[ST_L]) begin
      for (int i = 0; i < 3; i++) begin
        l_s1[i]    <= ldiff[i];
        lmag_s1[i] <= ldiff[i][LW-1] ? LW'(lrev[i]) : LW'(ldiff[i]);
        dir_s1[i]  <= dir_i[i];
      end
      rad_s1 <= rad_i;
    end
  end

  // ---------------------------------------------------------------------
  // Stage MUL: L * dir; squares of L and radius start here
  // ---------------------------------------------------------------------
  logic signed [PW-1:0]   pd_s2 [3];
  logic        [2*LW-1:0] lsq   [3];
  logic        [2*RB-1:0] rr_sq;
  rsi_sq_en_t             sq_en_a;

  assign sq_en_a = '{mul: en[ST_MUL], sum: en[ST_TCA]};

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      for (int i = 0; i < 3; i++) begin
        pd_s2[i] <= PW'(l_s1[i]) * PW'(dir_s1[i]);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lsq
    rsi_square #(.W(LW)) u_lsq (
      .clk (clk),
      .en  (sq_en_a),
      .x   (lmag_s1[i]),
      .y   (lsq[i])
    );
  end

  rsi_square #(.W(RB)) u_rsq (
    .clk (clk),
    .en  (sq_en_a),
    .x   (rad_s1),
    .y   (rr_sq)
  );

  // ---------------------------------------------------------------------
  // Stage TCA: dot product sum, floor shift to Q.F
  // ---------------------------------------------------------------------
  logic signed [DOTW-1:0] dot_sum;
  logic signed [TW-1:0]   tca_s3;

  assign dot_sum = DOTW'(pd_s2[0]) + DOTW'(pd_s2[1]) + DOTW'(pd_s2[2]);

  always_ff @(posedge clk) begin
    if (en[ST_TCA]) begin
      tca_s3 <= dot_sum[DOTW-1:F];
    end
  end

  // ---------------------------------------------------------------------
  // Stage LL: L . L; square of tca starts here
  // ---------------------------------------------------------------------
  logic        [LLW-1:0]   ll_s4;
  logic        [2*RB-1:0]  rr_s4;
  logic signed [TW-1:0]    tca_s4;
  logic        [TMW-1:0]   tca_mag;
  logic        [2*TMW-1:0] tt_sq;
  rsi_sq_en_t              sq_en_b;

  assign tca_mag = tca_s3[TW-1] ? TMW'(-tca_s3) : TMW'(tca_s3);
  assign sq_en_b = '{mul: en[ST_LL], sum: en[ST_TT]};

  rsi_square #(.W(TMW)) u_tsq (
    .clk (clk),
    .en  (sq_en_b),
    .x   (tca_mag),
    .y   (tt_sq)
  );

  always_ff @(posedge clk) begin
    if (en[ST_LL]) begin
      ll_s4  <= LLW'(lsq[0]) + LLW'(lsq[1]) + LLW'(lsq[2]);
      rr_s4  <= rr_sq;
      tca_s4 <= tca_s3;
    end
  end

  // Stage TT: waits on the tca square
  logic        [LLW-1:0]  ll_s5;
  logic        [2*RB-1:0] rr_s5;
  logic signed [TW-1:0]   tca_s5;

  always_ff @(posedge clk) begin
    if (en[ST_TT]) begin
      ll_s5  <= ll_s4;
      rr_s5  <= rr_s4;
      tca_s5 <= tca_s4;
    end
  end

  // Stage D2: d2 = L.L - tca^2 (may be negative for a non-unit direction)
  logic signed [XW-1:0]   d2_s6;
  logic        [2*RB-1:0] rr_s6;
  logic signed [TW-1:0]   tca_s6;

  always_ff @(posedge clk) begin
    if (en[ST_D2]) begin
      d2_s6  <= XW'(ll_s5) - XW'(tt_sq);
      rr_s6  <= rr_s5;
      tca_s6 <= tca_s5;
    end
  end

  // Stage DISC: r^2 - d2; negative means the ray passes outside
  logic        [XW-1:0] disc;
  logic        [SW-1:0] disc_s7;
  logic                 miss_s7;
  logic signed [TW-1:0] tca_s7;

  assign disc = XW'(rr_s6) - d2_s6;

  always_ff @(posedge clk) begin
    if (en[ST_DISC]) begin
      disc_s7 <= disc;
      miss_s7 <= disc[XW-1];
      tca_s7  <= tca_s6;
    end
  end

  // ---------------------------------------------------------------------
  // Square root: restoring, one root bit per stage, two radicand bits in
  // ---------------------------------------------------------------------
  logic        [N-1:0]  sq_root [N];
  logic        [RW-1:0] sq_rem  [N];
  logic        [SW-1:0] sq_x    [N];
  logic signed [TW-1:0] sq_tca  [N];
  logic                 sq_miss [N];

  for (genvar j = 0; j < N; j++) begin : g_sqrt
    logic        [N-1:0]  root_p;
    logic        [RW-1:0] rem_p;
    logic        [SW-1:0] x_p;
    logic signed [TW-1:0] tca_p;
    logic                 miss_p;
    logic        [RW-1:0] rem_sh;
    logic        [RW-1:0] trial;

    if (j == 0) begin : g_first
      assign root_p = '0;
      assign rem_p  = '0;
      assign x_p    = disc_s7;
      assign tca_p  = tca_s7;
      assign miss_p = miss_s7;
    end else begin : g_next
      assign root_p = sq_root[j-1];
      assign rem_p  = sq_rem[j-1];
      assign x_p    = sq_x[j-1];
      assign tca_p  = sq_tca[j-1];
      assign miss_p = sq_miss[j-1];
    end

    assign rem_sh = {rem_p[RW-3:0], x_p[SW-1-2*j -: 2]};
    assign trial  = {root_p, 2'b01};

    always_ff @(posedge clk) begin
      if (en[ST_SQ + j]) begin
        if (rem_sh >= trial) begin
          sq_rem[j]  <= rem_sh - trial;
          sq_root[j] <= {root_p[N-2:0], 1'b1};
        end else begin
          sq_rem[j]  <= rem_sh;
          sq_root[j] <= {root_p[N-2:0], 1'b0};
        end
        sq_x[j]    <= x_p;
        sq_tca[j]  <= tca_p;
        sq_miss[j] <= miss_p;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: pick the nearest non-negative root, saturate
  // ---------------------------------------------------------------------
  logic signed [OW-1:0] t_near;
  logic signed [OW-1:0] t_far;
  logic signed [OW-1:0] t_sel;
  logic                 hit_next;
  logic        [C-1:0]  dist_next;
  logic                 hit_q;
  logic        [C-1:0]  dist_q;

  always_comb begin
    t_near   = OW'(sq_tca[N-1]) - OW'(sq_root[N-1]);
    t_far    = OW'(sq_tca[N-1]) + OW'(sq_root[N-1]);
    t_sel    = t_near[OW-1] ? t_far : t_near;
    hit_next = !sq_miss[N-1] && !t_sel[OW-1];
    if (!hit_next) begin
      dist_next = '0;
    end else if (|t_sel[OW-1:C-1]) begin
      dist_next = {1'b0, {(C-1){1'b1}}};
    end else begin
      dist_next = t_sel[C-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      hit_q  <= hit_next;
      dist_q <= dist_next;
    end
  end

  assign m_tvalid = v[ST_OUT];
  assign m_tuser  = hit_q;
  assign m_tdata  = OUT_W'(dist_q);

endmodule

/* rtl/rsi_square.sv */
`timescale 1ns / 1ps

// Two-rank unsigned squarer: the operand is split in halves, three narrow
// partial products are registered, then combined into the full square.
module rsi_square #(
  parameter int W = 33
) (
  input  logic                 clk,
  input  rsi_pkg::rsi_sq_en_t  en,
  input  logic [W-1:0]         x,
  output logic [2*W-1:0]       y
);

  localparam int H  = (W + 1) / 2;
  localparam int HW = W - H;

  logic [HW-1:0]   x_hi;
  logic [H-1:0]    x_lo;
  logic [2*HW-1:0] p_hh;
  logic [W-1:0]    p_hl;
  logic [2*H-1:0]  p_ll;

  assign x_hi = x[W-1:H];
  assign x_lo = x[H-1:0];

  // partial products
  always_ff @(posedge clk) begin
    if (en.mul) begin
      p_hh <= (2*HW)'(x_hi) * (2*HW)'(x_hi);
      p_hl <= W'(x_hi) * W'(x_lo);
      p_ll <= (2*H)'(x_lo) * (2*H)'(x_lo);
    end
  end

  // hi^2 * 2^2H + 2 * hi * lo * 2^H + lo^2
  always_ff @(posedge clk) begin
    if (en.sum) begin
      y <= ((2*W)'(p_hh) << (2*H)) + ((2*W)'(p_hl) << (H + 1)) + (2*W)'(p_ll);
    end
  end

endmodule

/* rtl/rsi_checker.sv */
`timescale 1ns / 1ps

// Port-level checks for the intersection core
module rsi_checker #(
  parameter int COORD_BITS = rsi_pkg::COORD_BITS_DEF
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tready,
  input logic [((COORD_BITS+7)/8)*8-1:0]      m_tdata,
  input logic                                 m_tuser,
  input logic                                 m_tvalid,
  input logic                                 m_tready
);

  // nothing comes out straight after reset
  a_rst_empty: assert property (@(posedge clk) $past(rst) && !rst |-> !m_tvalid)
    else $error("result shown right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // a miss reports zero distance
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("miss with non-zero distance");

  // a hit distance is never negative
  a_hit_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[COORD_BITS-1])
    else $error("negative hit distance");

  // an empty output means the pipe can take a transfer
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind ray_sphere_intersect_core rsi_checker #(.COORD_BITS(COORD_BITS)) u_rsi_checker (.*);
